### rtl/clex_pkg.sv
// shared types, codes and constant tables of the c subset lexer
package clex_pkg;

    localparam int unsigned     MAX_TOKEN_LEN_DEF = 512;
    localparam longint unsigned STREAM_BYTES_DEF  = 64'd1048576;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 5;
    localparam int START_W = 20;
    localparam int LEN_W   = 10;

    typedef enum logic [KIND_W-1:0] {
        K_UNKNOWN    = 5'd0,
        K_NAME       = 5'd1,
        K_STRUCT     = 5'd2,
        K_RETURN     = 5'd3,
        K_IF         = 5'd4,
        K_ELSE       = 5'd5,
        K_NEWLINE    = 5'd6,
        K_PREPROC    = 5'd7,
        K_COMMENT    = 5'd8,
        K_FLOAT      = 5'd9,
        K_INT        = 5'd10,
        K_STRING     = 5'd11,
        K_LPAREN     = 5'd12,
        K_RPAREN     = 5'd13,
        K_LBRACK     = 5'd14,
        K_RBRACK     = 5'd15,
        K_LBRACE     = 5'd16,
        K_RBRACE     = 5'd17,
        K_SEMI       = 5'd18,
        K_STAR       = 5'd19,
        K_ASSIGN     = 5'd20,
        K_EQ         = 5'd21,
        K_COMMA      = 5'd22,
        K_ARROW      = 5'd23,
        K_PLUS       = 5'd24,
        K_MINUS      = 5'd25,
        K_INC        = 5'd26,
        K_DEC        = 5'd27,
        K_PLUSMINUS  = 5'd28,
        K_END        = 5'd29
    } t_kind;

    typedef enum logic [10:0] {
        M_IDLE    = 11'b000_0000_0001,
        M_NAME    = 11'b000_0000_0010,
        M_INT     = 11'b000_0000_0100,
        M_FLOAT   = 11'b000_0000_1000,
        M_STRING  = 11'b000_0001_0000,
        M_LINE    = 11'b000_0010_0000,
        M_COMMENT = 11'b000_0100_0000,
        M_SLASH   = 11'b000_1000_0000,
        M_EQ      = 11'b001_0000_0000,
        M_PLUS    = 11'b010_0000_0000,
        M_MINUS   = 11'b100_0000_0000
    } t_mode;

    typedef struct packed {
        t_kind              kind;
        logic [START_W-1:0] start;
        logic [LEN_W-1:0]   length;
        logic               too_long;
        logic               unterminated;
        logic               last_of_run;
    } t_token;

    // tokens one byte produced, handed from the scanner to the output buffer
    typedef struct packed {
        logic       vld;
        logic [1:0] cnt;
        t_token     tok0;
        t_token     tok1;
    } t_step;

    localparam logic [BYTE_W-1:0] CH_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0a;
    localparam logic [BYTE_W-1:0] CH_SP     = 8'h20;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [BYTE_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [BYTE_W-1:0] CH_STAR   = 8'h2a;
    localparam logic [BYTE_W-1:0] CH_PLUS   = 8'h2b;
    localparam logic [BYTE_W-1:0] CH_COMMA  = 8'h2c;
    localparam logic [BYTE_W-1:0] CH_MINUS  = 8'h2d;
    localparam logic [BYTE_W-1:0] CH_DOT    = 8'h2e;
    localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2f;
    localparam logic [BYTE_W-1:0] CH_SEMI   = 8'h3b;
    localparam logic [BYTE_W-1:0] CH_EQ     = 8'h3d;
    localparam logic [BYTE_W-1:0] CH_GT     = 8'h3e;
    localparam logic [BYTE_W-1:0] CH_LBRACK = 8'h5b;
    localparam logic [BYTE_W-1:0] CH_RBRACK = 8'h5d;
    localparam logic [BYTE_W-1:0] CH_LBRACE = 8'h7b;
    localparam logic [BYTE_W-1:0] CH_RBRACE = 8'h7d;

    // keyword spellings in order struct, return, if, else; unused places zero
    localparam int KW_N   = 4;
    localparam int KW_MAX = 6;
    localparam logic [BYTE_W-1:0] KW_TEXT [KW_N][KW_MAX] = '{
        '{8'h73, 8'h74, 8'h72, 8'h75, 8'h63, 8'h74},
        '{8'h72, 8'h65, 8'h74, 8'h75, 8'h72, 8'h6e},
        '{8'h69, 8'h66, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h65, 8'h6c, 8'h73, 8'h65, 8'h00, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_N] = '{3'd6, 3'd6, 3'd2, 3'd4};

endpackage

### rtl/clex_byte_if.sv
// source byte channel
interface clex_byte_if;
    import clex_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink   (input valid, input source_byte, output ready);
endinterface

### rtl/clex_token_if.sv
// token result channel
interface clex_token_if;
    import clex_pkg::*;

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  token_kind;
    logic [START_W-1:0] token_start;
    logic [LEN_W-1:0]   token_length;
    logic               too_long;
    logic               unterminated;
    logic               last_of_run;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output too_long, output unterminated,
                    output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input too_long, input unterminated,
                    input last_of_run, output ready);
endinterface

### rtl/clex_core.sv
// input register and per-byte scanner state update
module clex_core #(
    parameter int unsigned     MAX_TOKEN_LEN = clex_pkg::MAX_TOKEN_LEN_DEF,
    parameter longint unsigned STREAM_BYTES  = clex_pkg::STREAM_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    clex_byte_if.sink        i_byte,
    input  logic             i_free,
    output clex_pkg::t_step  o_step
);
    import clex_pkg::*;

    localparam int POS_W = $clog2(STREAM_BYTES);
    localparam int CL_W  = $clog2(MAX_TOKEN_LEN + 1);
    localparam logic [CL_W-1:0]  MAX_LEN  = CL_W'(MAX_TOKEN_LEN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(STREAM_BYTES - 64'd1);

    logic              r_in_vld;
    logic [BYTE_W-1:0] r_in_byte;

    t_mode             r_mode,  n_mode;
    logic [POS_W-1:0]  r_pos,   n_pos;
    logic [POS_W-1:0]  r_start, n_start;
    logic [CL_W-1:0]   r_len,   n_len;
    logic [KW_N-1:0]   r_kwc,   n_kwc;
    logic              r_sat,   n_sat;

    logic              fire;
    logic              is_alpha;
    logic              is_digit;
    logic [CL_W-1:0]   g_len;
    logic              g_sat;
    logic [KW_N-1:0]   kw_next;
    logic [KW_N-1:0]   kw_first;
    t_kind             name_kind;
    logic              a_vld, b_vld, taken;
    t_token            a_tok, b_tok;

    function automatic t_token mk_tok(t_kind kind, logic [POS_W-1:0] start,
                                      logic [CL_W-1:0] len, logic too,
                                      logic unterm);
        t_token t;
        t.kind         = kind;
        t.start        = START_W'(start);
        t.length       = LEN_W'(len);
        t.too_long     = too;
        t.unterminated = unterm;
        t.last_of_run  = 1'b0;
        return t;
    endfunction

    assign fire         = r_in_vld && i_free;
    assign i_byte.ready = !r_in_vld || fire;

    assign is_alpha = r_in_byte inside {[8'h41:8'h5a], [8'h61:8'h7a]};
    assign is_digit = r_in_byte inside {[8'h30:8'h39]};

    // saturating growth of the pending token
    assign g_len = (r_len < MAX_LEN) ? r_len + CL_W'(1) : r_len;
    assign g_sat = (r_len < MAX_LEN) ? r_sat : 1'b1;

    always_comb begin
        for (int k = 0; k < KW_N; k++) begin
            kw_next[k]  = r_kwc[k] && (r_len < CL_W'(KW_LEN[k]))
                          && (KW_TEXT[k][r_len[2:0]] == r_in_byte);
            kw_first[k] = (KW_TEXT[k][0] == r_in_byte);
        end
    end

    always_comb begin
        name_kind = K_NAME;
        if (!r_sat) begin
            if (r_kwc[0] && r_len == CL_W'(KW_LEN[0])) begin
                name_kind = K_STRUCT;
            end else if (r_kwc[1] && r_len == CL_W'(KW_LEN[1])) begin
                name_kind = K_RETURN;
            end else if (r_kwc[2] && r_len == CL_W'(KW_LEN[2])) begin
                name_kind = K_IF;
            end else if (r_kwc[3] && r_len == CL_W'(KW_LEN[3])) begin
                name_kind = K_ELSE;
            end
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_start = r_start;
        n_len   = r_len;
        n_sat   = r_sat;
        n_kwc   = r_kwc;
        n_pos   = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
        a_vld   = 1'b0;
        a_tok   = '0;
        b_vld   = 1'b0;
        b_tok   = '0;
        taken   = 1'b0;

        // close or extend the pending token
        case (r_mode)
            M_NAME: begin
                if (is_alpha || is_digit) begin
                    n_kwc = kw_next;
                    n_len = g_len;
                    n_sat = g_sat;
                    taken = 1'b1;
                end else begin
                    a_vld  = 1'b1;
                    a_tok  = mk_tok(name_kind, r_start, r_len, r_sat, 1'b0);
                    n_mode = M_IDLE;
                end
            end
            M_INT: begin
                if (is_digit) begin
                    n_len = g_len;
                    n_sat = g_sat;
                    taken = 1'b1;
                end else if (r_in_byte == CH_DOT) begin
                    n_len  = g_len;
                    n_sat  = g_sat;
                    n_mode = M_FLOAT;
                    taken  = 1'b1;
                end else begin
                    a_vld  = 1'b1;
                    a_tok  = mk_tok(K_INT, r_start, r_len, r_sat, 1'b0);
                    n_mode = M_IDLE;
                end
            end
            M_FLOAT: begin
                if (is_digit) begin
                    n_len = g_len;
                    n_sat = g_sat;
                    taken = 1'b1;
                end else begin
                    a_vld  = 1'b1;
                    a_tok  = mk_tok(K_FLOAT, r_start, r_len, r_sat, 1'b0);
                    n_mode = M_IDLE;
                end
            end
            M_STRING: begin
                n_len = g_len;
                n_sat = g_sat;
                if (r_in_byte == CH_QUOTE) begin
                    a_vld  = 1'b1;
                    a_tok  = mk_tok(K_STRING, r_start, g_len, g_sat, 1'b0);
                    n_mode = M_IDLE;
                    taken  = 1'b1;
                end else if (r_in_byte == CH_NUL) begin
                    // open string at end of input: closed and flagged
                    a_vld  = 1'b1;
                    a_tok  = mk_tok(K_STRING, r_start, g_len, g_sat, 1'b1);
                    n_mode = M_IDLE;
                end else begin
                    taken = 1'b1;
                end
            end
            M_LINE, M_COMMENT: begin
                if (r_in_byte == CH_NL || r_in_byte == CH_NUL) begin
                    a_vld  = 1'b1;
                    a_tok  = mk_tok((r_mode == M_LINE) ? K_PREPROC : K_COMMENT,
                                    r_start, r_len, r_sat, 1'b0);
                    n_mode = M_IDLE;
                end else begin
                    n_len = g_len;
                    n_sat = g_sat;
                    taken = 1'b1;
                end
            end
            M_SLASH: begin
                if (r_in_byte == CH_SLASH) begin
                    n_len  = g_len;
                    n_sat  = g_sat;
                    n_mode = M_COMMENT;
                    taken  = 1'b1;
                end else begin
                    // lone slash
                    a_vld  = 1'b1;
                    a_tok  = mk_tok(K_UNKNOWN, r_start, CL_W'(1), 1'b0, 1'b0);
                    n_mode = M_IDLE;
                end
            end
            M_EQ: begin
                a_vld  = 1'b1;
                n_mode = M_IDLE;
                if (r_in_byte == CH_EQ) begin
                    a_tok = mk_tok(K_EQ, r_start, CL_W'(2), 1'b0, 1'b0);
                    taken = 1'b1;
                end else begin
                    a_tok = mk_tok(K_ASSIGN, r_start, CL_W'(1), 1'b0, 1'b0);
                end
            end
            M_PLUS: begin
                a_vld  = 1'b1;
                n_mode = M_IDLE;
                if (r_in_byte == CH_PLUS) begin
                    a_tok = mk_tok(K_INC, r_start, CL_W'(2), 1'b0, 1'b0);
                    taken = 1'b1;
                end else if (r_in_byte == CH_MINUS) begin
                    a_tok = mk_tok(K_PLUSMINUS, r_start, CL_W'(2), 1'b0, 1'b0);
                    taken = 1'b1;
                end else begin
                    a_tok = mk_tok(K_PLUS, r_start, CL_W'(1), 1'b0, 1'b0);
                end
            end
            M_MINUS: begin
                a_vld  = 1'b1;
                n_mode = M_IDLE;
                if (r_in_byte == CH_GT) begin
                    a_tok = mk_tok(K_ARROW, r_start, CL_W'(2), 1'b0, 1'b0);
                    taken = 1'b1;
                end else if (r_in_byte == CH_MINUS) begin
                    a_tok = mk_tok(K_DEC, r_start, CL_W'(2), 1'b0, 1'b0);
                    taken = 1'b1;
                end else begin
                    a_tok = mk_tok(K_MINUS, r_start, CL_W'(1), 1'b0, 1'b0);
                end
            end
            default: begin
                n_mode = M_IDLE;
            end
        endcase

        // byte not absorbed: lex it from scratch
        if (!taken) begin
            case (r_in_byte)
                CH_NUL: begin
                    b_vld  = 1'b1;
                    b_tok  = mk_tok(K_END, r_pos, CL_W'(1), 1'b0, 1'b0);
                    n_mode = M_IDLE;
                    n_kwc  = '1;
                    n_pos  = '0;
                end
                CH_SP, CH_TAB: begin
                end
                CH_NL: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_NEWLINE, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_HASH, CH_SLASH, CH_QUOTE, CH_EQ, CH_PLUS, CH_MINUS: begin
                    n_start = r_pos;
                    n_len   = CL_W'(1);
                    n_sat   = 1'b0;
                    case (r_in_byte)
                        CH_HASH:  n_mode = M_LINE;
                        CH_SLASH: n_mode = M_SLASH;
                        CH_QUOTE: n_mode = M_STRING;
                        CH_EQ:    n_mode = M_EQ;
                        CH_PLUS:  n_mode = M_PLUS;
                        default:  n_mode = M_MINUS;
                    endcase
                end
                CH_LPAREN: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_LPAREN, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_RPAREN: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_RPAREN, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_LBRACK: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_LBRACK, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_RBRACK: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_RBRACK, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_LBRACE: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_LBRACE, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_RBRACE: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_RBRACE, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_SEMI: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_SEMI, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_STAR: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_STAR, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                CH_COMMA: begin
                    b_vld = 1'b1;
                    b_tok = mk_tok(K_COMMA, r_pos, CL_W'(1), 1'b0, 1'b0);
                end
                default: begin
                    if (is_alpha) begin
                        n_start = r_pos;
                        n_len   = CL_W'(1);
                        n_sat   = 1'b0;
                        n_kwc   = kw_first;
                        n_mode  = M_NAME;
                    end else if (is_digit) begin
                        n_start = r_pos;
                        n_len   = CL_W'(1);
                        n_sat   = 1'b0;
                        n_mode  = M_INT;
                    end else begin
                        b_vld = 1'b1;
                        b_tok = mk_tok(K_UNKNOWN, r_pos, CL_W'(1), 1'b0, 1'b0);
                    end
                end
            endcase
        end
    end

    // pack up to two tokens, the closing one first
    always_comb begin
        o_step.vld  = r_in_vld;
        o_step.cnt  = {1'b0, a_vld} + {1'b0, b_vld};
        o_step.tok0 = a_vld ? a_tok : b_tok;
        o_step.tok1 = b_tok;
        o_step.tok0.last_of_run = !(a_vld && b_vld);
        o_step.tok1.last_of_run = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_mode   <= M_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_kwc    <= '1;
            r_sat    <= 1'b0;
        end else begin
            if (i_byte.ready) begin
                r_in_vld <= i_byte.valid;
            end
            if (fire) begin
                r_mode  <= n_mode;
                r_pos   <= n_pos;
                r_start <= n_start;
                r_len   <= n_len;
                r_kwc   <= n_kwc;
                r_sat   <= n_sat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.ready) begin
            r_in_byte <= i_byte.source_byte;
        end
    end

endmodule

### rtl/clex_tokbuf.sv
// two-entry result buffer that hands tokens out one at a time
module clex_tokbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  clex_pkg::t_step i_step,
    output logic            o_free,
    clex_token_if.source    o_token
);
    import clex_pkg::*;

    logic [1:0] r_cnt, n_cnt;
    t_token     r_ent0, n_ent0;
    t_token     r_ent1, n_ent1;
    logic       pop;
    logic       push;

    assign o_token.valid        = (r_cnt != 2'd0);
    assign o_token.token_kind   = r_ent0.kind;
    assign o_token.token_start  = r_ent0.start;
    assign o_token.token_length = r_ent0.length;
    assign o_token.too_long     = r_ent0.too_long;
    assign o_token.unterminated = r_ent0.unterminated;
    assign o_token.last_of_run  = r_ent0.last_of_run;

    assign pop    = o_token.valid && o_token.ready;
    assign o_free = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_token.ready);
    assign push   = i_step.vld && o_free;

    always_comb begin
        n_cnt  = r_cnt;
        n_ent0 = r_ent0;
        n_ent1 = r_ent1;
        if (push) begin
            n_ent0 = i_step.tok0;
            n_ent1 = i_step.tok1;
            n_cnt  = i_step.cnt;
        end else if (pop) begin
            if (r_cnt == 2'd2) begin
                n_ent0 = r_ent1;
                n_cnt  = 2'd1;
            end else begin
                n_cnt  = 2'd0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent0 <= n_ent0;
        r_ent1 <= n_ent1;
    end

endmodule

### rtl/c_subset_lexer.sv
// streaming lexer for a small c-like language, one source byte per item
//
// channels: i_byte takes one source byte per item (zero ends the stream);
// o_token gives one token per item: kind, start offset, length and flags,
// with last_of_run marking the final token a byte caused.
// order: a byte accepted sits in the input register, its tokens are
// written to the result buffer once that buffer is free and are offered
// to o_token from there. tokens whose kind depends on the following
// byte (names, numbers, = + - / and lines) come out when that following
// byte is processed; a string comes out with its closing quote or zero.
// throughput: one byte per cycle while each byte yields at most one token
// and o_token takes it; a byte yielding two tokens holds the input register
// until the single-token output port has drained the buffer to one entry.
// reset: the scanner goes idle between tokens, the position counter is
// cleared and both registers are emptied.
// stall: when o_token is held, the buffer keeps its tokens, the input
// register holds its byte and i_byte.ready drops once both are full.
module c_subset_lexer #(
    parameter int unsigned     MAX_TOKEN_LEN = clex_pkg::MAX_TOKEN_LEN_DEF,
    parameter longint unsigned STREAM_BYTES  = clex_pkg::STREAM_BYTES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    clex_byte_if.sink     i_byte,
    clex_token_if.source  o_token
);
    import clex_pkg::*;

    // tokens of the byte in the input register
    t_step w_step;
    // buffer can take a whole byte's tokens this cycle
    logic  w_free;

    // scanner: input register plus next-state and token logic
    clex_core #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN),
        .STREAM_BYTES  (STREAM_BYTES)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_byte),
        .i_free  (w_free),
        .o_step  (w_step)
    );

    // result register: holds up to two tokens and serialises them
    clex_tokbuf u_tokbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .o_free  (w_free),
        .o_token (o_token)
    );

endmodule

### dv/tb_c_subset_lexer.sv
// self-checking testbench of the c subset lexer: byte stimulus, token prediction and checking
module tb_c_subset_lexer;
    import clex_pkg::*;

    localparam int CYCLE_LIMIT   = 200_000;    // far above a run with the longest stalls
    localparam int DRAIN_LIMIT   = 20_000;
    localparam int SETTLE_CYCLES = 8;          // settling margin after the expected tokens are in
    localparam int RANDOM_ITEMS  = 120;
    localparam int HOLD_CYCLES   = 300;        // long receiver hold-off, fills the block

    // token scoreboard: runs its own copy of the scanner on every accepted byte
    // and queues the tokens that byte should cause
    class token_scoreboard;
        t_token              expected_tokens[$];
        t_token              run_tokens[$];
        int unsigned         fail_count;
        t_mode               mode;
        logic [START_W-1:0]  pos;
        logic [START_W-1:0]  tok_start;
        int unsigned         tok_len;
        logic                saturated;
        logic [KW_N-1:0]     kw_mask;

        function new();
            fail_count = 0;
            mode       = M_IDLE;
            pos        = '0;
            tok_start  = '0;
            tok_len    = 0;
            saturated  = 1'b0;
            kw_mask    = '1;
        endfunction

        function bit is_alpha(logic [BYTE_W-1:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [BYTE_W-1:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function void emit(t_kind k, logic [START_W-1:0] s, int unsigned len,
                           logic too, logic unterm);
            t_token t;
            t.kind         = k;
            t.start        = s;
            t.length       = LEN_W'(len);
            t.too_long     = too;
            t.unterminated = unterm;
            t.last_of_run  = 1'b0;
            run_tokens.push_back(t);
        endfunction

        function void emit_pending(t_kind k, logic unterm);
            emit(k, tok_start, tok_len, saturated, unterm);
        endfunction

        // length sticks at the maximum and raises the too-long flag
        function void grow();
            if (tok_len < MAX_TOKEN_LEN_DEF)
                tok_len++;
            else
                saturated = 1'b1;
        endfunction

        function void open_token(logic [START_W-1:0] p);
            tok_start = p;
            tok_len   = 1;
            saturated = 1'b0;
        endfunction

        // drop every keyword that is too short or whose spelling differs at the current offset
        function void narrow_keywords(logic [BYTE_W-1:0] c);
            for (int k = 0; k < KW_N; k++) begin
                if (tok_len >= KW_LEN[k] || KW_TEXT[k][tok_len] != c)
                    kw_mask[k] = 1'b0;
            end
        endfunction

        function t_kind name_kind();
            if (!saturated) begin
                for (int k = 0; k < KW_N; k++) begin
                    if (kw_mask[k] && tok_len == KW_LEN[k])
                        return t_kind'(int'(K_STRUCT) + k);
                end
            end
            return K_NAME;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] c);
            logic [START_W-1:0] p;
            bit                 taken;
            p     = pos;
            taken = 1'b0;
            run_tokens.delete();

            // first let the byte finish or extend a pending token
            case (mode)
                M_NAME: begin
                    if (is_alpha(c) || is_digit(c)) begin
                        narrow_keywords(c);
                        grow();
                        taken = 1'b1;
                    end else begin
                        emit_pending(name_kind(), 1'b0);
                        mode = M_IDLE;
                    end
                end
                M_INT: begin
                    if (is_digit(c)) begin
                        grow();
                        taken = 1'b1;
                    end else if (c == CH_DOT) begin
                        grow();
                        mode  = M_FLOAT;
                        taken = 1'b1;
                    end else begin
                        emit_pending(K_INT, 1'b0);
                        mode = M_IDLE;
                    end
                end
                M_FLOAT: begin
                    if (is_digit(c)) begin
                        grow();
                        taken = 1'b1;
                    end else begin
                        emit_pending(K_FLOAT, 1'b0);
                        mode = M_IDLE;
                    end
                end
                M_STRING: begin
                    grow();
                    if (c == CH_QUOTE) begin
                        emit_pending(K_STRING, 1'b0);
                        mode  = M_IDLE;
                        taken = 1'b1;
                    end else if (c == CH_NUL) begin
                        emit_pending(K_STRING, 1'b1);
                        mode = M_IDLE;
                    end else begin
                        taken = 1'b1;
                    end
                end
                M_LINE, M_COMMENT: begin
                    if (c == CH_NL || c == CH_NUL) begin
                        emit_pending((mode == M_LINE) ? K_PREPROC : K_COMMENT, 1'b0);
                        mode = M_IDLE;
                    end else begin
                        grow();
                        taken = 1'b1;
                    end
                end
                M_SLASH: begin
                    if (c == CH_SLASH) begin
                        grow();
                        mode  = M_COMMENT;
                        taken = 1'b1;
                    end else begin
                        emit(K_UNKNOWN, tok_start, 1, 1'b0, 1'b0);
                        mode = M_IDLE;
                    end
                end
                M_EQ: begin
                    if (c == CH_EQ) begin
                        emit(K_EQ, tok_start, 2, 1'b0, 1'b0);
                        taken = 1'b1;
                    end else begin
                        emit(K_ASSIGN, tok_start, 1, 1'b0, 1'b0);
                    end
                    mode = M_IDLE;
                end
                M_PLUS: begin
                    if (c == CH_PLUS) begin
                        emit(K_INC, tok_start, 2, 1'b0, 1'b0);
                        taken = 1'b1;
                    end else if (c == CH_MINUS) begin
                        emit(K_PLUSMINUS, tok_start, 2, 1'b0, 1'b0);
                        taken = 1'b1;
                    end else begin
                        emit(K_PLUS, tok_start, 1, 1'b0, 1'b0);
                    end
                    mode = M_IDLE;
                end
                M_MINUS: begin
                    if (c == CH_GT) begin
                        emit(K_ARROW, tok_start, 2, 1'b0, 1'b0);
                        taken = 1'b1;
                    end else if (c == CH_MINUS) begin
                        emit(K_DEC, tok_start, 2, 1'b0, 1'b0);
                        taken = 1'b1;
                    end else begin
                        emit(K_MINUS, tok_start, 1, 1'b0, 1'b0);
                    end
                    mode = M_IDLE;
                end
                default: mode = M_IDLE;
            endcase

            // then, unless consumed, lex it from the idle state
            if (!taken) begin
                case (c)
                    CH_NUL: begin
                        emit(K_END, p, 1, 1'b0, 1'b0);
                        mode    = M_IDLE;
                        kw_mask = '1;
                    end
                    CH_SP, CH_TAB: ;
                    CH_NL:     emit(K_NEWLINE, p, 1, 1'b0, 1'b0);
                    CH_HASH:   begin open_token(p); mode = M_LINE;   end
                    CH_SLASH:  begin open_token(p); mode = M_SLASH;  end
                    CH_QUOTE:  begin open_token(p); mode = M_STRING; end
                    CH_LPAREN: emit(K_LPAREN, p, 1, 1'b0, 1'b0);
                    CH_RPAREN: emit(K_RPAREN, p, 1, 1'b0, 1'b0);
                    CH_LBRACK: emit(K_LBRACK, p, 1, 1'b0, 1'b0);
                    CH_RBRACK: emit(K_RBRACK, p, 1, 1'b0, 1'b0);
                    CH_LBRACE: emit(K_LBRACE, p, 1, 1'b0, 1'b0);
                    CH_RBRACE: emit(K_RBRACE, p, 1, 1'b0, 1'b0);
                    CH_SEMI:   emit(K_SEMI, p, 1, 1'b0, 1'b0);
                    CH_STAR:   emit(K_STAR, p, 1, 1'b0, 1'b0);
                    CH_COMMA:  emit(K_COMMA, p, 1, 1'b0, 1'b0);
                    CH_EQ:     begin open_token(p); mode = M_EQ;    end
                    CH_PLUS:   begin open_token(p); mode = M_PLUS;  end
                    CH_MINUS:  begin open_token(p); mode = M_MINUS; end
                    default: begin
                        if (is_alpha(c)) begin
                            open_token(p);
                            kw_mask = '1;
                            tok_len = 0;
                            narrow_keywords(c);
                            tok_len = 1;
                            mode    = M_NAME;
                        end else if (is_digit(c)) begin
                            open_token(p);
                            mode = M_INT;
                        end else begin
                            emit(K_UNKNOWN, p, 1, 1'b0, 1'b0);
                        end
                    end
                endcase
            end

            // end of input restarts the offset, otherwise it wraps at the counter width
            if (!taken && c == CH_NUL)
                pos = '0;
            else
                pos = p + 1'b1;

            if (run_tokens.size() > 0)
                run_tokens[run_tokens.size() - 1].last_of_run = 1'b1;
            foreach (run_tokens[i])
                expected_tokens.push_back(run_tokens[i]);
        endfunction

        function void check_field(string field, logic [START_W-1:0] exp_val,
                                  logic [START_W-1:0] act_val);
            if (act_val !== exp_val) begin
                $error("%s: expected %0d, got %0d", field, exp_val, act_val);
                fail_count++;
            end
        endfunction

        function void check_token(t_token actual);
            t_token exp_tok;
            if (expected_tokens.size() == 0) begin
                $error("token with none expected: kind %0d start %0d length %0d",
                       actual.kind, actual.start, actual.length);
                fail_count++;
                return;
            end
            exp_tok = expected_tokens.pop_front();
            check_field("token_kind",   exp_tok.kind,         actual.kind);
            check_field("token_start",  exp_tok.start,        actual.start);
            check_field("token_length", exp_tok.length,       actual.length);
            check_field("too_long",     exp_tok.too_long,     actual.too_long);
            check_field("unterminated", exp_tok.unterminated, actual.unterminated);
            check_field("last_of_run",  exp_tok.last_of_run,  actual.last_of_run);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    clex_byte_if  src_ch ();
    clex_token_if tok_ch ();

    c_subset_lexer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (src_ch),
        .o_token (tok_ch)
    );

    token_scoreboard sb;
    string           keyword_text [4] = '{"struct", "return", "if", "else"};
    string           symbol_text      = "(){}[];*,";
    string           operator_text [8] = '{"=", "==", "+", "++", "+-", "-", "->", "--"};

    bit          src_idle_en;
    bit          sink_idle_en;
    bit          hold_request;
    int unsigned bytes_sent;
    int unsigned cycle_count;

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // both channels sampled at the rising edge
    always @(posedge i_clk) begin
        t_token actual;
        if (i_rst_n) begin
            if (src_ch.valid && src_ch.ready)
                sb.note_byte(src_ch.source_byte);
            if (tok_ch.valid && tok_ch.ready) begin
                actual.kind         = t_kind'(tok_ch.token_kind);
                actual.start        = tok_ch.token_start;
                actual.length       = tok_ch.token_length;
                actual.too_long     = tok_ch.too_long;
                actual.unterminated = tok_ch.unterminated;
                actual.last_of_run  = tok_ch.last_of_run;
                sb.check_token(actual);
            end
        end
    end

    // token receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int stall_left;
        int hold_left;
        stall_left   = 0;
        hold_left    = 0;
        tok_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0) begin
                tok_ch.ready = 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                tok_ch.ready = 1'b0;
                stall_left--;
            end else if (sink_idle_en && $urandom_range(0, 7) == 0) begin
                tok_ch.ready = 1'b0;
                stall_left   = $urandom_range(1, 9) - 1;
            end else begin
                tok_ch.ready = 1'b1;
            end
        end
    end

    // offer one byte from a falling edge, hold it until accepted, return at a falling edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (src_idle_en && $urandom_range(0, 7) == 0) begin
            gap          = $urandom_range(1, 9);
            src_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        src_ch.valid       = 1'b1;
        src_ch.source_byte = b;
        @(posedge i_clk);
        while (!src_ch.ready) @(posedge i_clk);
        bytes_sent++;
        @(negedge i_clk);
        // nothing on offer until the next byte is given
        src_ch.valid = 1'b0;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [BYTE_W-1:0] rand_alnum();
        case ($urandom_range(0, 2))
            0:       return 8'("a" + $urandom_range(0, 25));
            1:       return 8'("A" + $urandom_range(0, 25));
            default: return 8'("0" + $urandom_range(0, 9));
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] rand_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    // any non-zero byte except the one that would end the token
    function automatic logic [BYTE_W-1:0] rand_body(logic [BYTE_W-1:0] stop);
        logic [BYTE_W-1:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == stop);
        return b;
    endfunction

    // one well-formed token with random content, or noise
    task automatic send_random_token();
        string             kw;
        int                n;
        logic [BYTE_W-1:0] sym;
        kw = keyword_text[$urandom_range(0, 3)];
        case ($urandom_range(0, 15))
            0, 1: begin
                case ($urandom_range(0, 3))
                    0: send_text(kw);
                    1: begin send_text(kw); send_byte(rand_alnum()); end
                    2: send_text(kw.substr(0, kw.len() - 2));
                    default: begin
                        send_byte(8'("a" + $urandom_range(0, 25)));
                        repeat ($urandom_range(0, 9)) send_byte(rand_alnum());
                    end
                endcase
            end
            2: repeat ($urandom_range(1, 6)) send_byte(rand_digit());
            3: begin
                repeat ($urandom_range(1, 4)) send_byte(rand_digit());
                send_byte(CH_DOT);
                repeat ($urandom_range(0, 4)) send_byte(rand_digit());
            end
            4: begin
                send_byte(CH_QUOTE);
                repeat ($urandom_range(0, 12)) send_byte(rand_body(CH_QUOTE));
                // now and then leave it open so end of input closes it
                send_byte(($urandom_range(0, 7) == 0) ? CH_NUL : CH_QUOTE);
            end
            5, 6: begin
                if ($urandom_range(0, 1) == 0)
                    send_byte(CH_HASH);
                else
                    send_text("//");
                repeat ($urandom_range(0, 10)) send_byte(rand_body(CH_NL));
                send_byte(($urandom_range(0, 5) == 0) ? CH_NUL : CH_NL);
            end
            7: begin
                send_byte(CH_SLASH);
                send_byte(rand_body(CH_SLASH));
            end
            8: begin
                n = $urandom_range(0, symbol_text.len() - 1);
                send_byte(symbol_text[n]);
            end
            9: send_text(operator_text[$urandom_range(0, 7)]);
            10: repeat ($urandom_range(1, 3))
                    send_byte(($urandom_range(0, 1) == 0) ? CH_SP : CH_TAB);
            11: send_byte(CH_NL);
            12: send_byte(8'($urandom_range(1, 255)));
            13: send_byte(CH_NUL);
            default: begin
                sym = ($urandom_range(0, 1) == 0) ? CH_SP : CH_TAB;
                send_byte(sym);
            end
        endcase
    endtask

    task automatic wait_for_tokens();
        int guard;
        guard = 0;
        while (sb.expected_tokens.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        int unsigned first;
        bit          pressure_done;
        sb                 = new();
        i_rst_n            = 1'b0;
        src_ch.valid       = 1'b0;
        src_ch.source_byte = '0;
        src_idle_en        = 1'b1;
        sink_idle_en       = 1'b1;
        hold_request       = 1'b0;
        bytes_sent         = 0;
        cycle_count        = 0;
        pressure_done      = 1'b0;

        // synchronous reset
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: top byte values, lone slash, string left open at end of input
        send_byte(8'hff);
        send_byte(8'h80);
        send_text("/x\"a");
        send_byte(CH_NUL);
        // keyword, double equals, then a float still pending at end of input
        send_text("if==1.5");
        send_byte(CH_NUL);
        // preprocessor line and comment each closed by a newline, so two tokens per byte
        send_byte(CH_HASH);
        send_byte(8'h7f);
        send_byte(CH_NL);
        send_text("//");
        send_byte(CH_NL);
        send_byte(CH_NUL);

        // long token: a string that saturates and is closed by end of input
        send_byte(CH_QUOTE);
        repeat (MAX_TOKEN_LEN_DEF - 1) send_byte(rand_body(CH_QUOTE));
        send_byte(CH_NUL);

        // random token streams, with idling switched on and off in stretches
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 39) == 0) begin
                src_idle_en  = ($urandom_range(0, 2) != 0);
                sink_idle_en = ($urandom_range(0, 2) != 0);
            end
            // one long receiver hold-off while bytes keep coming
            if (!pressure_done && bytes_sent - first >= 40) begin
                hold_request  = 1'b1;
                pressure_done = 1'b1;
            end
            send_random_token();
        end
        send_byte(CH_NUL);
        wait_for_tokens();

        // last part at full rate on both sides
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (15) send_random_token();
        send_byte(CH_NUL);
        src_ch.valid = 1'b0;

        wait_for_tokens();
        if (sb.expected_tokens.size() != 0) begin
            $error("%0d expected tokens never arrived", sb.expected_tokens.size());
            sb.fail_count++;
        end
        if (sb.fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
